FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the weighted channel averager.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/wca_pkg.sv
// Package for the weighted channel averager: word types, field widths,
// register indexes and back-end state encoding. Depends on nothing.
package wca_pkg;

  localparam int VALUE_W  = 24;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = VALUE_W + WEIGHT_W;
  localparam int GSIZE_W  = 13;
  localparam int AVG_W    = 24;
  localparam int WT_W     = 28;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [0:0]         REG_GROUP_SIZE = 1'b0;
  localparam logic [GSIZE_W-1:0] GSIZE_RESET    = 13'd1;

  localparam logic [AVG_W-1:0] AVG_MAX = 24'h7FFFFF;
  localparam logic [AVG_W-1:0] AVG_MIN = 24'h800000;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       spectrum_end;
  } sample_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic signed [WT_W-1:0]  weight_total;
    logic                    spectrum_last;
  } result_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_SAT,
    DIV_HOLD
  } div_state_t;

endpackage

FILE: src/wca_front.sv
// Front end of the weighted channel averager: multiplies, counts channels
// and accumulates each group, pushing closed groups to the queue. Uses wca_pkg.
module wca_front #(
  parameter int MAX_GROUP = 4096,
  parameter int PSUM_W    = 52,
  parameter int WSUM_W    = 28,
  parameter int CNT_W     = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wca_pkg::GSIZE_W-1:0]   group_size,
  input  wca_pkg::sample_t              sample,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  wca_pkg::q_status_t            q_status,
  output logic                          push,
  output logic signed [PSUM_W-1:0]      push_psum,
  output logic signed [WSUM_W-1:0]      push_wsum,
  output logic                          push_last
);
  import wca_pkg::*;

  localparam int CMP_W = (CNT_W > GSIZE_W) ? CNT_W : GSIZE_W;

  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_inc;
  logic [CMP_W-1:0]           size_eff;
  logic                       closes;
  logic                       take;
  logic                       go;
  logic                       s1_valid;
  logic signed [PROD_W-1:0]   s1_prod;
  logic signed [WEIGHT_W-1:0] s1_weight;
  logic                       s1_last;
  logic                       s1_close;
  logic signed [PSUM_W-1:0]   psum;
  logic signed [PSUM_W-1:0]   psum_next;
  logic signed [WSUM_W-1:0]   wsum;
  logic signed [WSUM_W-1:0]   wsum_next;

  always_comb begin
    priority if (group_size == '0) begin
      size_eff = CMP_W'(1);
    end else if (CMP_W'(group_size) > CMP_W'(MAX_GROUP)) begin
      size_eff = CMP_W'(MAX_GROUP);
    end else begin
      size_eff = CMP_W'(group_size);
    end
  end

  assign count_inc    = count + 1'b1;
  assign closes       = (CMP_W'(count_inc) >= size_eff) || sample.spectrum_end;
  assign go           = s1_valid && (!s1_close || !q_status.full);
  assign sample_stall = s1_valid && !go;
  assign take         = sample_valid && !sample_stall;

  assign psum_next = psum + PSUM_W'(s1_prod);
  assign wsum_next = wsum + WSUM_W'(s1_weight);

  assign push      = go && s1_close;
  assign push_psum = psum_next;
  assign push_wsum = wsum_next;
  assign push_last = s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      count    <= '0;
      psum     <= '0;
      wsum     <= '0;
    end else begin
      if (!sample_stall) begin
        s1_valid <= sample_valid;
      end
      if (take) begin
        count <= closes ? '0 : count_inc;
      end
      if (go) begin
        if (s1_close) begin
          psum <= '0;
          wsum <= '0;
        end else begin
          psum <= psum_next;
          wsum <= wsum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_prod   <= sample.value * sample.weight;
      s1_weight <= sample.weight;
      s1_last   <= sample.spectrum_end;
      s1_close  <= closes;
    end
  end

endmodule

FILE: src/wca_queue.sv
// Short queue of closed groups between the front end and the divider.
// Uses wca_pkg for the status word.
module wca_queue #(
  parameter int W     = 81,
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [W-1:0]       push_data,
  input  logic               pop,
  output logic [W-1:0]       pop_data,
  output wca_pkg::q_status_t status
);
  import wca_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.valid = (count != '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: src/wca_back.sv
// Back end of the weighted channel averager: restoring divider, saturation
// and the output word register. Uses wca_pkg.
module wca_back #(
  parameter int PSUM_W = 52,
  parameter int WSUM_W = 28
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  logic signed [PSUM_W-1:0] q_psum,
  input  logic signed [WSUM_W-1:0] q_wsum,
  input  logic                     q_last,
  output logic                     pop,
  output wca_pkg::result_t         result,
  output logic                     result_valid,
  input  logic                     result_stall
);
  import wca_pkg::*;

  localparam int SW = $clog2(PSUM_W);

  div_state_t        state;
  div_state_t        state_next;
  logic              neg;
  logic [PSUM_W-1:0] dvd;
  logic [WSUM_W-1:0] dvs;
  logic [WSUM_W-1:0] rem;
  logic [SW-1:0]     step;
  logic [WSUM_W:0]   trial;
  logic [WSUM_W:0]   diff;
  logic              trial_ge;
  logic              big;
  logic [AVG_W-1:0]  avg_sat;
  logic [AVG_W-1:0]  avg_q;
  logic [WT_W-1:0]   wt_q;
  logic              last_q;

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: begin
        if (q_valid) begin
          state_next = (q_wsum > 0) ? DIV_RUN : DIV_HOLD;
        end
      end
      DIV_RUN: begin
        if (step == SW'(PSUM_W - 1)) begin
          state_next = DIV_SAT;
        end
      end
      DIV_SAT:  state_next = DIV_HOLD;
      DIV_HOLD: begin
        if (!result_stall) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    pop          = (state == DIV_IDLE) && q_valid;
    result_valid = (state == DIV_HOLD);
  end

  assign trial    = {rem, dvd[PSUM_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign trial_ge = (trial >= {1'b0, dvs});

  always_comb begin
    if (neg) begin
      big     = (|dvd[PSUM_W-1:AVG_W]) || (dvd[AVG_W-1] && (|dvd[AVG_W-2:0]));
      avg_sat = big ? AVG_MIN : -dvd[AVG_W-1:0];
    end else begin
      big     = |dvd[PSUM_W-1:AVG_W-1];
      avg_sat = big ? AVG_MAX : dvd[AVG_W-1:0];
    end
  end

  always_comb begin
    result.average       = avg_q;
    result.weight_total  = wt_q;
    result.spectrum_last = last_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DIV_IDLE: begin
        if (q_valid) begin
          neg    <= q_psum[PSUM_W-1];
          dvd    <= q_psum[PSUM_W-1] ? -q_psum : q_psum;
          dvs    <= q_wsum;
          rem    <= '0;
          step   <= '0;
          last_q <= q_last;
          avg_q  <= '0;
          wt_q   <= (q_wsum > 0) ? WT_W'(q_wsum) : '0;
        end
      end
      DIV_RUN: begin
        rem  <= trial_ge ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
        dvd  <= {dvd[PSUM_W-2:0], trial_ge};
        step <= step + 1'b1;
      end
      DIV_SAT: begin
        avg_q <= avg_sat;
      end
      DIV_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/weighted_channel_averager.sv
// Top level of the weighted channel averager: configuration registers and
// the front end, group queue and divider. Uses wca_pkg and assert_macros.svh.
//
// Channel words are accepted one per clock while sample_stall is low. Each
// word is multiplied and added into the open group's product and weight sums;
// when the group reaches the configured size, or a word carries the spectrum
// end mark, the sums go into a two-entry queue. The back end divides each
// closed group with a restoring divider that retires one quotient bit per
// clock (the product sum is PSUM_W = 40 + clog2(MAX_GROUP) bits wide), then
// saturates the quotient and holds the output word while result_stall is
// high. Closed groups back up through the queue while the divider is busy,
// and the input is stalled when a group closes on a full queue until the
// divider frees an entry.
// A group whose weight sum is not positive skips the divider and gives zeros.
// Group size 0 counts as 1; sizes above MAX_GROUP count as MAX_GROUP.
`include "assert_macros.svh"

module weighted_channel_averager #(
  parameter int MAX_GROUP = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wca_pkg::sample_t             sample,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  output wca_pkg::result_t             result,
  output logic                         result_valid,
  input  logic                         result_stall,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wca_pkg::ADDR_W-1:0]   paddr,
  input  logic [wca_pkg::DATA_W-1:0]   pwdata,
  output logic [wca_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import wca_pkg::*;

  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int PSUM_W = PROD_W + $clog2(MAX_GROUP);
  localparam int WSUM_W = WEIGHT_W + $clog2(MAX_GROUP);
  localparam int QW     = PSUM_W + WSUM_W + 1;

  logic [GSIZE_W-1:0]       group_size;
  logic [0:0]               reg_index;
  logic                     reg_write;
  q_status_t                q_status;
  logic                     q_push;
  logic                     q_pop;
  logic signed [PSUM_W-1:0] push_psum;
  logic signed [WSUM_W-1:0] push_wsum;
  logic                     push_last;
  logic [QW-1:0]            q_in;
  logic [QW-1:0]            q_out;
  logic signed [PSUM_W-1:0] q_psum;
  logic signed [WSUM_W-1:0] q_wsum;
  logic                     q_last;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_index == REG_GROUP_SIZE) begin
      prdata = DATA_W'(group_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GSIZE_RESET;
    end else if (reg_write && (reg_index == REG_GROUP_SIZE)) begin
      group_size <= pwdata[GSIZE_W-1:0];
    end
  end

  wca_front #(
    .MAX_GROUP (MAX_GROUP),
    .PSUM_W    (PSUM_W),
    .WSUM_W    (WSUM_W),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .group_size   (group_size),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .q_status     (q_status),
    .push         (q_push),
    .push_psum    (push_psum),
    .push_wsum    (push_wsum),
    .push_last    (push_last)
  );

  assign q_in = {push_last, push_wsum, push_psum};

  wca_queue #(
    .W     (QW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  assign q_psum = q_out[PSUM_W-1:0];
  assign q_wsum = q_out[PSUM_W+WSUM_W-1:PSUM_W];
  assign q_last = q_out[QW-1];

  wca_back #(
    .PSUM_W (PSUM_W),
    .WSUM_W (WSUM_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_status.valid),
    .q_psum       (q_psum),
    .q_wsum       (q_wsum),
    .q_last       (q_last),
    .pop          (q_pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  `ASSERT_IMPLIES(a_no_push_when_full, q_push, !q_status.full, "group pushed into a full queue")
  `ASSERT_IMPLIES(a_pop_needs_entry, q_pop, q_status.valid, "divider popped an empty queue")
  `ASSERT_NEXT(a_push_lands, q_push, q_status.valid, "pushed group not visible in the queue")

endmodule
